### design/pms_pkg.sv
// Shared types and constants for the PWM melody sequencer.
// Used by every module of the block except pms_ram; depends on nothing.
`default_nettype none

package pms_pkg;

	// Note table
	localparam int TABLE_DEPTH = 256;
	localparam int TBL_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int ENTRY_W = 32;
	localparam int MAX_LEN = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;

	// Timing
	localparam int GAP_MS = 10;

	// Field widths
	localparam int OP_W = 2;
	localparam int IDX_W = 8;
	localparam int FREQ_W = 16;
	localparam int DUR_W = 16;
	localparam int LEN_W = 9;
	localparam int VAL_W = 16;
	localparam int CLK_W = 28;
	localparam int DUTY_W = 7;

	// Tone arithmetic
	localparam int DIV_W = CLK_W;
	localparam int DIV_CW = $clog2(DIV_W + 1);
	localparam int PERIOD_W = VAL_W + 1;
	localparam int PROD_W = PERIOD_W + DUTY_W;
	localparam int RELOAD_MAX = 16'hFFFF;
	localparam int PERIOD_MIN = 2;
	localparam int DUTY_MAX = 100;
	localparam int DUTY_FALLBACK = 50;
	localparam int PCT_DIV = 100;
	// Divide by 100 as multiply by ceil(2^30/100) and shift right by 30; exact for every
	// period times duty product (at most 65536 * 100)
	localparam int PCT_SHIFT = 30;
	localparam int PCT_RECIP = 10737419;
	localparam int RECIP_W = 24;
	localparam int SCALE_W = PROD_W + RECIP_W;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam int CLK_HZ_RESET = 1000000;
	localparam int DUTY_RESET = 50;
	localparam logic REG_CLK_HZ = 1'b0;
	localparam logic REG_DUTY = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_TICK  = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_READ,
		ST_TONE,
		ST_DIV_PER,
		ST_MUL,
		ST_SCALE,
		ST_APPLY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [IDX_W-1:0]  note_index;
		logic [FREQ_W-1:0] note_freq_hz;
		logic [DUR_W-1:0]  note_duration_ms;
		logic [LEN_W-1:0]  melody_length;
	} item_t;

	typedef struct packed {
		logic [VAL_W-1:0] reload_value;
		logic [VAL_W-1:0] compare_value;
		logic             busy_res;
		logic             error;
		logic [IDX_W-1:0] note_position;
		logic             in_gap;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic load_item;
		logic ram_we;
		logic ram_re;
		logic do_start;
		logic do_tick;
		logic do_halt;
		logic set_err;
		logic latch_entry;
		logic rest_apply;
		logic div_start;
		logic latch_period;
		logic latch_prod;
		logic latch_cmp;
		logic tone_apply;
		logic load_out;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		op_t  op;
		logic len_zero;
		logic tick_advance;
		logic is_rest;
		logic div_done;
		logic period_bad;
		logic out_free;
	} dp_sts_t;

endpackage

`default_nettype wire

### design/pms_if.sv
// Valid/ready channel interfaces for the item and result streams.
// Payload widths come from pms_pkg.
`default_nettype none

interface pms_item_if;
	logic                      valid;
	logic                      ready;
	logic [pms_pkg::OP_W-1:0]   op;
	logic [pms_pkg::IDX_W-1:0]  note_index;
	logic [pms_pkg::FREQ_W-1:0] note_freq_hz;
	logic [pms_pkg::DUR_W-1:0]  note_duration_ms;
	logic [pms_pkg::LEN_W-1:0]  melody_length;

	modport source (output valid, output op, output note_index, output note_freq_hz,
		output note_duration_ms, output melody_length, input ready);
	modport sink (input valid, input op, input note_index, input note_freq_hz,
		input note_duration_ms, input melody_length, output ready);
endinterface

interface pms_result_if;
	logic                     valid;
	logic                     ready;
	logic [pms_pkg::VAL_W-1:0] reload_value;
	logic [pms_pkg::VAL_W-1:0] compare_value;
	logic                     busy_res;
	logic                     error;
	logic [pms_pkg::IDX_W-1:0] note_position;
	logic                     in_gap;

	modport source (output valid, output reload_value, output compare_value,
		output busy_res, output error, output note_position, output in_gap, input ready);
	modport sink (input valid, input reload_value, input compare_value,
		input busy_res, input error, input note_position, input in_gap, output ready);
endinterface

`default_nettype wire

### design/pms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module pms_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic                             re,
	input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### design/pms_div.sv
// Restoring divider, one quotient bit per cycle, for the tone period.
// Widths from pms_pkg.
`default_nettype none

module pms_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [pms_pkg::DIV_W-1:0] dividend,
	input  wire logic [pms_pkg::DIV_W-1:0] divisor,
	output logic                           done,
	output logic      [pms_pkg::DIV_W-1:0] quotient
);

	logic [pms_pkg::DIV_CW-1:0] cnt_q;
	logic [pms_pkg::DIV_W-1:0]  rem_q;
	logic [pms_pkg::DIV_W-1:0]  quo_q;
	logic [pms_pkg::DIV_W-1:0]  dsr_q;
	logic                       done_q;
	logic [pms_pkg::DIV_W:0]    shifted;
	logic [pms_pkg::DIV_W:0]    diff;
	logic                       fits;

	assign shifted = {rem_q, quo_q[pms_pkg::DIV_W-1]};
	assign diff = shifted - {1'b0, dsr_q};
	assign fits = (shifted >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= pms_pkg::DIV_CW'(pms_pkg::DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				done_q <= (cnt_q == pms_pkg::DIV_CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (cnt_q != '0) begin
			// shift in the next dividend bit, subtract when it fits
			rem_q <= fits ? diff[pms_pkg::DIV_W-1:0] : shifted[pms_pkg::DIV_W-1:0];
			quo_q <= {quo_q[pms_pkg::DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

### design/pms_ctrl.sv
// Controller state machine: sequences decode, table read, tone math and result hand-off.
// Uses state_t, op_t and the command/status structs of pms_pkg.
`default_nettype none

module pms_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire pms_pkg::dp_sts_t sts,
	output pms_pkg::dp_cmd_t      cmd
);

	pms_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pms_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pms_pkg::ST_IDLE: begin
				if (in_valid) state_d = pms_pkg::ST_DECODE;
			end
			pms_pkg::ST_DECODE: begin
				unique case (sts.op)
					pms_pkg::OP_WRITE: state_d = pms_pkg::ST_DONE;
					pms_pkg::OP_START:
						state_d = sts.len_zero ? pms_pkg::ST_DONE : pms_pkg::ST_READ;
					pms_pkg::OP_TICK:
						state_d = sts.tick_advance ? pms_pkg::ST_READ : pms_pkg::ST_DONE;
					pms_pkg::OP_STOP: state_d = pms_pkg::ST_DONE;
					default: state_d = pms_pkg::ST_DONE;
				endcase
			end
			pms_pkg::ST_READ: state_d = pms_pkg::ST_TONE;
			pms_pkg::ST_TONE: begin
				state_d = sts.is_rest ? pms_pkg::ST_DONE : pms_pkg::ST_DIV_PER;
			end
			pms_pkg::ST_DIV_PER: begin
				if (sts.div_done) begin
					state_d = sts.period_bad ? pms_pkg::ST_DONE : pms_pkg::ST_MUL;
				end
			end
			pms_pkg::ST_MUL: state_d = pms_pkg::ST_SCALE;
			pms_pkg::ST_SCALE: state_d = pms_pkg::ST_APPLY;
			pms_pkg::ST_APPLY: state_d = pms_pkg::ST_DONE;
			pms_pkg::ST_DONE: begin
				if (sts.out_free) state_d = pms_pkg::ST_IDLE;
			end
			default: state_d = pms_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			pms_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load_item = in_valid;
			end
			pms_pkg::ST_DECODE: begin
				unique case (sts.op)
					pms_pkg::OP_WRITE: cmd.ram_we = 1'b1;
					pms_pkg::OP_START: begin
						cmd.set_err = sts.len_zero;
						cmd.do_start = !sts.len_zero;
					end
					pms_pkg::OP_TICK: cmd.do_tick = 1'b1;
					pms_pkg::OP_STOP: cmd.do_halt = 1'b1;
					default: cmd.do_halt = 1'b1;
				endcase
			end
			pms_pkg::ST_READ: cmd.ram_re = 1'b1;
			pms_pkg::ST_TONE: begin
				cmd.latch_entry = 1'b1;
				cmd.rest_apply = sts.is_rest;
				cmd.div_start = !sts.is_rest;
			end
			pms_pkg::ST_DIV_PER: begin
				if (sts.div_done) begin
					cmd.set_err = sts.period_bad;
					cmd.do_halt = sts.period_bad;
					cmd.latch_period = !sts.period_bad;
				end
			end
			pms_pkg::ST_MUL: cmd.latch_prod = 1'b1;
			pms_pkg::ST_SCALE: cmd.latch_cmp = 1'b1;
			pms_pkg::ST_APPLY: cmd.tone_apply = 1'b1;
			pms_pkg::ST_DONE: cmd.load_out = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/pms_datapath.sv
// Datapath: item registers, note table, playback state, tone arithmetic, result register.
// Instantiates pms_ram and pms_div; types and constants from pms_pkg.
`default_nettype none

module pms_datapath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire pms_pkg::item_t             item,
	input  wire logic [pms_pkg::CLK_W-1:0]  clk_hz,
	input  wire logic [pms_pkg::DUTY_W-1:0] duty,
	input  wire pms_pkg::dp_cmd_t           cmd,
	output pms_pkg::dp_sts_t                sts,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output pms_pkg::result_t                result
);

	// latched item
	pms_pkg::item_t item_q;

	// playback state
	logic [pms_pkg::IDX_W-1:0]    cur_idx_q;
	logic [pms_pkg::LEN_W-1:0]    act_len_q;
	logic                         playing_q;
	logic                         gap_q;
	logic [pms_pkg::DUR_W-1:0]    rem_q;
	logic [pms_pkg::VAL_W-1:0]    reload_q;
	logic [pms_pkg::VAL_W-1:0]    compare_q;
	logic                         err_q;

	// tone math
	logic [pms_pkg::DUR_W-1:0]    dur_q;
	logic [pms_pkg::PERIOD_W-1:0] period_q;
	logic [pms_pkg::PROD_W-1:0]   prod_q;
	logic [pms_pkg::PERIOD_W-1:0] cmp_q;

	// result register
	logic                         res_valid_q;
	pms_pkg::result_t             result_q;

	logic [31:0]                  wr_idx_ext;
	logic [31:0]                  rd_idx_ext;
	logic                         wr_in_table;
	logic [pms_pkg::ENTRY_W-1:0]  ram_rdata;
	logic [pms_pkg::FREQ_W-1:0]   entry_freq;
	logic [pms_pkg::DIV_W-1:0]    div_dividend;
	logic [pms_pkg::DIV_W-1:0]    div_divisor;
	logic                         div_done;
	logic [pms_pkg::DIV_W-1:0]    div_quo;
	logic [pms_pkg::DUTY_W-1:0]   duty_eff;
	logic [pms_pkg::PERIOD_W-1:0] arr;
	logic [pms_pkg::SCALE_W-1:0]  scaled;
	logic [pms_pkg::PERIOD_W-1:0] cmp_clamped;
	logic [pms_pkg::LEN_W-1:0]    len_sat;
	logic [pms_pkg::DUR_W-1:0]    rem_dec;
	logic                         last_note;

	assign wr_idx_ext = 32'(item_q.note_index);
	assign rd_idx_ext = 32'(cur_idx_q);
	assign wr_in_table = (wr_idx_ext < 32'(pms_pkg::TABLE_DEPTH));

	pms_ram #(
		.WIDTH(pms_pkg::ENTRY_W),
		.DEPTH(pms_pkg::TABLE_DEPTH)
	) u_note_table (
		.clk  (clk),
		.we   (cmd.ram_we && wr_in_table),
		.waddr(wr_idx_ext[pms_pkg::TBL_AW-1:0]),
		.wdata({item_q.note_freq_hz, item_q.note_duration_ms}),
		.re   (cmd.ram_re),
		.raddr(rd_idx_ext[pms_pkg::TBL_AW-1:0]),
		.rdata(ram_rdata)
	);

	assign entry_freq = ram_rdata[pms_pkg::ENTRY_W-1:pms_pkg::DUR_W];

	assign div_dividend = clk_hz;
	assign div_divisor = pms_pkg::DIV_W'(entry_freq);

	pms_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign duty_eff = (duty > pms_pkg::DUTY_W'(pms_pkg::DUTY_MAX))
		? pms_pkg::DUTY_W'(pms_pkg::DUTY_FALLBACK) : duty;
	assign arr = period_q - 1'b1;
	// period times duty over 100 by reciprocal multiply
	assign scaled = pms_pkg::SCALE_W'(prod_q) * pms_pkg::SCALE_W'(pms_pkg::PCT_RECIP);
	assign cmp_clamped = (cmp_q > arr) ? arr : cmp_q;

	assign len_sat = (32'(item_q.melody_length) > 32'(pms_pkg::MAX_LEN))
		? pms_pkg::LEN_W'(pms_pkg::MAX_LEN) : item_q.melody_length;
	assign rem_dec = (rem_q == '0) ? '0 : rem_q - 1'b1;
	assign last_note = ((pms_pkg::LEN_W'(cur_idx_q) + 1'b1) >= act_len_q);

	always_comb begin
		sts.op = pms_pkg::op_t'(item_q.op);
		sts.len_zero = (item_q.melody_length == '0);
		sts.tick_advance = playing_q && (rem_dec == '0) && gap_q && !last_note;
		sts.is_rest = (entry_freq == '0);
		sts.div_done = div_done;
		sts.period_bad = (div_quo < pms_pkg::DIV_W'(pms_pkg::PERIOD_MIN))
			|| (div_quo > pms_pkg::DIV_W'(pms_pkg::RELOAD_MAX + 1));
		sts.out_free = !res_valid_q || res_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) item_q <= item;
		if (cmd.latch_entry) dur_q <= ram_rdata[pms_pkg::DUR_W-1:0];
		if (cmd.latch_period) period_q <= div_quo[pms_pkg::PERIOD_W-1:0];
		if (cmd.latch_prod) prod_q <= pms_pkg::PROD_W'(period_q) * pms_pkg::PROD_W'(duty_eff);
		if (cmd.latch_cmp) begin
			cmp_q <= scaled[pms_pkg::PCT_SHIFT+pms_pkg::PERIOD_W-1:pms_pkg::PCT_SHIFT];
		end
		if (cmd.load_out) begin
			result_q.reload_value <= reload_q;
			result_q.compare_value <= compare_q;
			result_q.busy_res <= playing_q;
			result_q.error <= err_q;
			result_q.note_position <= cur_idx_q;
			result_q.in_gap <= gap_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_idx_q <= '0;
			act_len_q <= '0;
			playing_q <= 1'b0;
			gap_q <= 1'b0;
			rem_q <= '0;
			reload_q <= '0;
			compare_q <= '0;
			err_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.load_item) err_q <= 1'b0;
			else if (cmd.set_err) err_q <= 1'b1;

			if (cmd.load_out) res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;

			priority if (cmd.do_halt) begin
				compare_q <= '0;
				playing_q <= 1'b0;
				act_len_q <= '0;
				cur_idx_q <= '0;
				gap_q <= 1'b0;
				rem_q <= '0;
			end else if (cmd.do_start) begin
				act_len_q <= len_sat;
				cur_idx_q <= '0;
				playing_q <= 1'b1;
			end else if (cmd.do_tick) begin
				if (playing_q) begin
					if (rem_dec != '0) begin
						rem_q <= rem_dec;
					end else if (!gap_q) begin
						// note over: silence and start the gap
						compare_q <= '0;
						gap_q <= 1'b1;
						rem_q <= pms_pkg::DUR_W'(pms_pkg::GAP_MS);
					end else if (last_note) begin
						compare_q <= '0;
						playing_q <= 1'b0;
						act_len_q <= '0;
						cur_idx_q <= '0;
						gap_q <= 1'b0;
						rem_q <= '0;
					end else begin
						// advance; the tone setup follows
						cur_idx_q <= cur_idx_q + 1'b1;
						rem_q <= '0;
					end
				end
			end else if (cmd.rest_apply) begin
				compare_q <= '0;
				gap_q <= 1'b0;
				rem_q <= ram_rdata[pms_pkg::DUR_W-1:0];
			end else if (cmd.tone_apply) begin
				reload_q <= arr[pms_pkg::VAL_W-1:0];
				compare_q <= cmp_clamped[pms_pkg::VAL_W-1:0];
				gap_q <= 1'b0;
				rem_q <= dur_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign result = result_q;

endmodule

`default_nettype wire

### design/pwm_melody_sequencer.sv
// Top level of the PWM melody sequencer: channel ports, APB register file, and the
// controller/datapath pair. Depends on pms_pkg, pms_if, pms_ctrl and pms_datapath.
//
// The block takes one item at a time on cmd and returns exactly one result on res per
// item. A note write, a start with zero length, a stop or a tick that does not begin a
// new note goes from the decode state to the done state, which loads its result into the
// output register. A start, or a tick that moves to the next note, reads the note table
// (registered RAM read data), then sets up the tone: a rest, an unplayable tone or a
// sounding tone, by the one-bit-per-cycle divider for counter clock over frequency, then
// the period times duty product, a reciprocal multiply for the division by 100 and the
// update, each in a state of its own. A new item can be taken as soon as the result is
// in the output register, while it still waits to be taken; the next result waits until
// that one leaves. The note table has no reset; entries must be written before they are
// played. The registers counter_clock_hz (address 0) and pwm_duty (address 4) are to be
// written over APB by the user only while the block is idle; the block does not check it.
`default_nettype none

module pwm_melody_sequencer (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	pms_item_if.sink                          cmd,
	pms_result_if.source                      res,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pms_pkg::APB_AW-1:0]   paddr,
	input  wire logic [pms_pkg::APB_DW-1:0]   pwdata,
	output logic      [pms_pkg::APB_DW-1:0]   prdata,
	output logic                              pready
);

	logic [pms_pkg::CLK_W-1:0]  clk_hz_q;
	logic [pms_pkg::DUTY_W-1:0] duty_q;
	logic                       reg_sel;
	logic                       wr_en;
	pms_pkg::item_t             item;
	pms_pkg::result_t           result;
	pms_pkg::dp_cmd_t           dp_cmd;
	pms_pkg::dp_sts_t           dp_sts;
	logic                       in_ready;
	logic                       res_valid;

	assign reg_sel = paddr[2];
	assign wr_en = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= pms_pkg::CLK_W'(pms_pkg::CLK_HZ_RESET);
			duty_q <= pms_pkg::DUTY_W'(pms_pkg::DUTY_RESET);
		end else if (wr_en) begin
			unique case (reg_sel)
				pms_pkg::REG_CLK_HZ: clk_hz_q <= pwdata[pms_pkg::CLK_W-1:0];
				pms_pkg::REG_DUTY: duty_q <= pwdata[pms_pkg::DUTY_W-1:0];
				default: duty_q <= duty_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			pms_pkg::REG_CLK_HZ: prdata = pms_pkg::APB_DW'(clk_hz_q);
			pms_pkg::REG_DUTY: prdata = pms_pkg::APB_DW'(duty_q);
			default: prdata = '0;
		endcase
	end

	assign item.op = cmd.op;
	assign item.note_index = cmd.note_index;
	assign item.note_freq_hz = cmd.note_freq_hz;
	assign item.note_duration_ms = cmd.note_duration_ms;
	assign item.melody_length = cmd.melody_length;
	assign cmd.ready = in_ready;

	pms_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(cmd.valid),
		.in_ready(in_ready),
		.sts     (dp_sts),
		.cmd     (dp_cmd)
	);

	pms_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.clk_hz   (clk_hz_q),
		.duty     (duty_q),
		.cmd      (dp_cmd),
		.sts      (dp_sts),
		.res_valid(res_valid),
		.res_ready(res.ready),
		.result   (result)
	);

	assign res.valid = res_valid;
	assign res.reload_value = result.reload_value;
	assign res.compare_value = result.compare_value;
	assign res.busy_res = result.busy_res;
	assign res.error = result.error;
	assign res.note_position = result.note_position;
	assign res.in_gap = result.in_gap;

endmodule

`default_nettype wire
